// File: rtl/assert_macros.svh
// Assertion macros used by the context table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/ctpl_pkg.sv
// Shared types, constants and functions of the context prefix table
package ctpl_pkg;

	localparam int unsigned ENTRIES_DEF = 16;
	localparam int unsigned FULL_LEN    = 128;
	localparam int unsigned ID_W        = 4;
	localparam int unsigned LEN_W       = 8;
	localparam int unsigned EXP_W       = 33;
	localparam int unsigned NOW_W       = 32;
	localparam int unsigned LIFE_W      = 16;
	localparam int unsigned CNT_W       = 5;

	typedef enum logic [2:0] {
		FN_UPDATE  = 3'd0,
		FN_LOOKUP  = 3'd1,
		FN_BY_ID   = 3'd2,
		FN_COUNT   = 3'd3,
		FN_REMOVE  = 3'd4,
		FN_PURGE   = 3'd5,
		FN_RSVD6   = 3'd6,
		FN_RSVD7   = 3'd7
	} func_t;

	typedef struct packed {
		logic [63:0]      ph;
		logic [63:0]      pl;
		logic [LEN_W-1:0] len;
		logic [EXP_W-1:0] expiry;
	} entry_t;

	typedef struct packed {
		func_t             func;
		logic [ID_W-1:0]   id;
		logic [127:0]      addr;
		logic [LEN_W-1:0]  len;
		logic [LIFE_W-1:0] life;
		logic [NOW_W-1:0]  now;
	} op_t;

	typedef struct packed {
		logic              found;
		logic [ID_W-1:0]   id;
		logic [63:0]       ph;
		logic [63:0]       pl;
		logic [LEN_W-1:0]  len;
		logic [LIFE_W-1:0] rem;
		logic [CNT_W-1:0]  cnt;
	} result_t;

	// top len bits set, len at most 128
	function automatic logic [127:0] mask128(input logic [LEN_W-1:0] len);
		mask128 = ~({128{1'b1}} >> len);
	endfunction

endpackage

// File: rtl/context_prefix_table_lpm_top.sv
// Top level of the context prefix table with longest-prefix match
//
// One operation enters on the s_axis channel; tuser carries the operation
// code, tdata the identifier, address, length, lifetime and current minute.
// Every operation gives exactly one result transfer on m_axis.
// The entries sit in a ring of cells that, while an operation is busy, rotates
// one place per cycle past a single head unit, which matches, rewrites and
// scores each entry in turn. An operation walks the whole ring and then hands
// its score to the output register; only then is a new operation accepted.
// The next operation is accepted while a result still waits on m_axis.
// A stalled receiver holds the result; a finished walk then waits and the
// input stays closed until the output register frees.
// Reset clears every entry at once; no sweep is needed.
`include "assert_macros.svh"

module context_prefix_table_lpm_top #(
	parameter int unsigned ENTRIES = ctpl_pkg::ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// entry_id[3:0], address_high[67:4], address_low[131:68],
	// prefix_length_in[139:132], lifetime_in[155:140], now_minutes[187:156], zero
	input  logic [191:0] s_axis_tdata,
	// func[2:0]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// found[0], result_id[4:1], prefix_high[68:5], prefix_low[132:69],
	// prefix_length_out[140:133], remaining_minutes[156:141], live_count[161:157], zero
	output logic [167:0] m_axis_tdata
);

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	logic              busy_q, fin_q, out_valid_q;
	logic [IW-1:0]     step_q;
	ctpl_pkg::op_t     op_q;
	ctpl_pkg::result_t out_q, res;
	ctpl_pkg::entry_t  cur [ENTRIES];
	ctpl_pkg::entry_t  head_new;
	logic              accept;

	assign s_axis_tready = !busy_q && !fin_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			if (g == ENTRIES - 1) begin : g_tail
				ctpl_cell u_cell (
					.clk(clk), .arst_n(arst_n), .shift(busy_q),
					.nxt(head_new), .cur(cur[g])
				);
			end else begin : g_mid
				ctpl_cell u_cell (
					.clk(clk), .arst_n(arst_n), .shift(busy_q),
					.nxt(cur[g+1]), .cur(cur[g])
				);
			end
		end
	endgenerate

	ctpl_head #(.IW(IW)) u_head (
		.clk(clk), .arst_n(arst_n), .start(accept), .en(busy_q),
		.step(step_q), .op(op_q), .ent(cur[0]), .ent_new(head_new), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			if (fin_q && (!out_valid_q || m_axis_tready)) begin
				fin_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q.func <= ctpl_pkg::func_t'(s_axis_tuser);
			op_q.id   <= s_axis_tdata[3:0];
			op_q.addr <= {s_axis_tdata[67:4], s_axis_tdata[131:68]};
			op_q.len  <= s_axis_tdata[139:132];
			op_q.life <= s_axis_tdata[155:140];
			op_q.now  <= s_axis_tdata[187:156];
		end
		if (fin_q && (!out_valid_q || m_axis_tready)) out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_q.cnt, out_q.rem, out_q.len, out_q.pl, out_q.ph,
		out_q.id, out_q.found};

	`ASSERT_ALWAYS(a_busy_fin_excl, !(busy_q === 1'b1 && fin_q === 1'b1),
		"walk and finish overlap")
	`ASSERT_CLK(a_fin_after_walk, $rose(fin_q) |-> $past(busy_q && step_q == LAST),
		"finish without a full walk")
	`ASSERT_CLK(a_step_range, busy_q |-> step_q <= LAST, "step beyond last entry")
	`ASSERT_CLK(a_no_lost_result, (fin_q && out_valid_q && !m_axis_tready) |=> fin_q,
		"pending result dropped")

endmodule

// File: rtl/ctpl_cell.sv
// One context cell of the rotating entry chain
module ctpl_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift,
	input  ctpl_pkg::entry_t      nxt,
	output ctpl_pkg::entry_t      cur
);

	ctpl_pkg::entry_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (shift) begin
			ent_q <= nxt;
		end
	end

	assign cur = ent_q;

endmodule

// File: rtl/ctpl_head.sv
// Head of the chain: examines, rewrites and scores the entry passing by
module ctpl_head #(
	parameter int unsigned IW = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 en,
	input  logic [IW-1:0]        step,
	input  ctpl_pkg::op_t        op,
	input  ctpl_pkg::entry_t     ent,
	output ctpl_pkg::entry_t     ent_new,
	output ctpl_pkg::result_t    res
);

	ctpl_pkg::result_t res_q;
	logic              have_q;

	logic                               live, hit_id, match, upd_ok;
	logic [ctpl_pkg::LEN_W-1:0]         clamp_len;
	logic [127:0]                       emask, umask;
	ctpl_pkg::entry_t                   upd_ent, cap_ent;
	logic                               capture, clear;
	logic [ctpl_pkg::EXP_W-1:0]         now_x, diff;
	logic [ctpl_pkg::LIFE_W-1:0]        rem;

	always_comb begin
		now_x     = {1'b0, op.now};
		live      = (ent.len != '0) && (now_x < ent.expiry);
		hit_id    = (op.id == ctpl_pkg::ID_W'(step));
		emask     = ctpl_pkg::mask128(ent.len);
		match     = (ent.len != '0) && ((({ent.ph, ent.pl} ^ op.addr) & emask) == '0);
		upd_ok    = (op.len != '0) && (op.life != '0);
		clamp_len = (op.len > ctpl_pkg::LEN_W'(ctpl_pkg::FULL_LEN)) ?
			ctpl_pkg::LEN_W'(ctpl_pkg::FULL_LEN) : op.len;
		umask     = ctpl_pkg::mask128(clamp_len);
		upd_ent.ph     = op.addr[127:64] & umask[127:64];
		upd_ent.pl     = op.addr[63:0] & umask[63:0];
		upd_ent.len    = clamp_len;
		upd_ent.expiry = now_x + ctpl_pkg::EXP_W'(op.life);

		capture = 1'b0;
		clear   = 1'b0;
		cap_ent = ent;
		ent_new = ent;
		case (op.func)
			ctpl_pkg::FN_UPDATE: begin
				if (hit_id && upd_ok) begin
					ent_new = upd_ent;
					cap_ent = upd_ent;
					capture = 1'b1;
				end
			end
			ctpl_pkg::FN_LOOKUP: begin
				if (match) begin
					if (live) capture = !have_q || (res_q.len < ent.len);
					else clear = 1'b1;
				end
			end
			ctpl_pkg::FN_BY_ID: begin
				if (hit_id) begin
					if (live) capture = 1'b1;
					else clear = 1'b1;
				end
			end
			ctpl_pkg::FN_COUNT, ctpl_pkg::FN_PURGE: begin
				clear = !live;
			end
			ctpl_pkg::FN_REMOVE: begin
				clear = hit_id;
			end
			default: begin
			end
		endcase
		if (clear) ent_new = '0;

		diff = cap_ent.expiry - now_x;
		if (cap_ent.expiry <= now_x) rem = '0;
		else if (diff > ctpl_pkg::EXP_W'(16'hFFFF)) rem = '1;
		else rem = diff[ctpl_pkg::LIFE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q  <= '0;
			have_q <= 1'b0;
		end else if (start) begin
			res_q  <= '0;
			have_q <= 1'b0;
		end else if (en) begin
			if (capture) begin
				have_q       <= 1'b1;
				res_q.found  <= 1'b1;
				res_q.id     <= ctpl_pkg::ID_W'(step);
				res_q.ph     <= cap_ent.ph;
				res_q.pl     <= cap_ent.pl;
				res_q.len    <= cap_ent.len;
				res_q.rem    <= rem;
			end
			if (op.func == ctpl_pkg::FN_COUNT && live) begin
				res_q.cnt   <= res_q.cnt + 1'b1;
				res_q.found <= 1'b1;
			end
		end
	end

	assign res = res_q;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the context prefix table with longest-prefix match
`timescale 1ns / 1ps

module tb;

	localparam int unsigned NENT      = 16;
	localparam int unsigned N_RANDOM  = 730;
	localparam int unsigned CYCLE_CAP = 300000;

	typedef struct packed {
		logic        found;
		logic [3:0]  id;
		logic [63:0] ph;
		logic [63:0] pl;
		logic [7:0]  len;
		logic [15:0] rem;
		logic [4:0]  cnt;
	} answer_t;

	typedef struct {
		ctpl_pkg::func_t fn;
		logic [3:0]  id;
		logic [63:0] ah;
		logic [63:0] al;
		logic [7:0]  len;
		logic [15:0] life;
		logic [31:0] now;
		bit          typed;
		answer_t     want;
	} request_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata = '0;
	logic [2:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [167:0] m_axis_tdata;

	context_prefix_table_lpm_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// shadow copy of the context store
	logic [63:0] ctx_ph[NENT];
	logic [63:0] ctx_pl[NENT];
	logic [7:0]  ctx_len[NENT];
	logic [32:0] ctx_exp[NENT];

	request_t  pending_ops[$];
	answer_t   awaited[$];
	request_t  cur;
	int        accepted = 0;
	int        total_ops = 0;
	int        errors = 0;
	int        cycles = 0;
	bit        stim_done = 1'b0;

	function automatic logic [127:0] len_mask(input int unsigned l);
		if (l >= 128) return {128{1'b1}};
		return ~({128{1'b1}} >> l);
	endfunction

	function automatic bit ctx_live(input int unsigned i, input logic [31:0] now);
		return ctx_len[i] != 0 && {1'b0, now} < ctx_exp[i];
	endfunction

	function automatic void ctx_clear(input int unsigned i);
		ctx_ph[i] = '0;
		ctx_pl[i] = '0;
		ctx_len[i] = '0;
		ctx_exp[i] = '0;
	endfunction

	function automatic answer_t ctx_report(input int unsigned i, input logic [31:0] now);
		answer_t a;
		logic [32:0] r;
		a = '0;
		r = ctx_exp[i] > {1'b0, now} ? ctx_exp[i] - {1'b0, now} : 33'd0;
		a.found = 1'b1;
		a.id = i[3:0];
		a.ph = ctx_ph[i];
		a.pl = ctx_pl[i];
		a.len = ctx_len[i];
		a.rem = r > 33'hFFFF ? 16'hFFFF : r[15:0];
		return a;
	endfunction

	// apply one operation to the shadow store and give its result
	function automatic answer_t table_apply(input request_t q);
		answer_t a;
		logic [127:0] m;
		int unsigned l;
		int unsigned best;
		int unsigned n;
		bit have;
		a = '0;
		have = 1'b0;
		best = 0;
		n = 0;
		case (q.fn)
			ctpl_pkg::FN_UPDATE: if (q.len != 0 && q.life != 0) begin
				l = q.len > 128 ? 128 : q.len;
				m = len_mask(l);
				ctx_len[q.id] = l[7:0];
				{ctx_ph[q.id], ctx_pl[q.id]} = {q.ah, q.al} & m;
				ctx_exp[q.id] = {1'b0, q.now} + q.life;
				a = ctx_report(q.id, q.now);
			end
			ctpl_pkg::FN_LOOKUP: begin
				for (int unsigned i = 0; i < NENT; i++) begin
					l = ctx_len[i];
					if (l == 0) continue;
					if ((({q.ah, q.al} ^ {ctx_ph[i], ctx_pl[i]}) & len_mask(l)) != 0) continue;
					if (ctx_live(i, q.now)) begin
						if (!have || ctx_len[best] < l) begin
							best = i;
							have = 1'b1;
						end
					end else
						ctx_clear(i);
				end
				if (have) a = ctx_report(best, q.now);
			end
			ctpl_pkg::FN_BY_ID: begin
				if (ctx_live(q.id, q.now)) a = ctx_report(q.id, q.now);
				else ctx_clear(q.id);
			end
			ctpl_pkg::FN_COUNT: begin
				for (int unsigned i = 0; i < NENT; i++)
					if (ctx_live(i, q.now)) n++;
					else ctx_clear(i);
				a.found = n != 0;
				a.cnt = n[4:0];
			end
			ctpl_pkg::FN_REMOVE: ctx_clear(q.id);
			ctpl_pkg::FN_PURGE: begin
				for (int unsigned i = 0; i < NENT; i++)
					if (!ctx_live(i, q.now)) ctx_clear(i);
			end
			default: ;
		endcase
		return a;
	endfunction

	function automatic request_t mk_op(input ctpl_pkg::func_t fn, input logic [3:0] id,
			input logic [63:0] ah, input logic [63:0] al, input logic [7:0] len,
			input logic [15:0] life, input logic [31:0] now);
		request_t q;
		q.fn = fn; q.id = id; q.ah = ah; q.al = al;
		q.len = len; q.life = life; q.now = now;
		q.typed = 1'b0;
		q.want = '0;
		return q;
	endfunction

	function automatic request_t with_answer(input request_t q, input answer_t a);
		q.typed = 1'b1;
		q.want = a;
		return q;
	endfunction

	function automatic answer_t hit(input logic [3:0] id, input logic [63:0] ph,
			input logic [63:0] pl, input logic [7:0] len, input logic [15:0] rem);
		answer_t a;
		a = '0;
		a.found = 1'b1; a.id = id; a.ph = ph; a.pl = pl; a.len = len; a.rem = rem;
		return a;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// phase of idling follows progress through the stimulus
	function automatic int unsigned send_idle_pct();
		if (accepted < total_ops / 3) return 9;
		if (accepted < 2 * total_ops / 3) return 55;
		return 0;
	endfunction

	function automatic int unsigned recv_idle_pct();
		if (accepted < total_ops / 3) return 55;
		if (accepted < 2 * total_ops / 3) return 9;
		return 0;
	endfunction

	// stimulus table and random part
	initial begin
		logic [63:0] bh[4];
		logic [63:0] bl[4];
		logic [127:0] tail;
		logic [31:0] now;
		int unsigned k;
		int unsigned r;
		request_t q;
		answer_t none;
		none = '0;

		pending_ops.push_back(with_answer(mk_op(ctpl_pkg::FN_COUNT, 0, 0, 0, 0, 0, 0), none));
		pending_ops.push_back(with_answer(mk_op(ctpl_pkg::FN_BY_ID, 0, 0, 0, 0, 0, 0), none));
		pending_ops.push_back(with_answer(mk_op(ctpl_pkg::FN_UPDATE, 0, '1, '1, 0, 10, 1),
			none));
		pending_ops.push_back(with_answer(mk_op(ctpl_pkg::FN_UPDATE, 0, '1, '1, 8, 0, 1),
			none));
		pending_ops.push_back(with_answer(mk_op(ctpl_pkg::FN_UPDATE, 15, '1, '1, 255,
			16'hFFFF, 5), hit(15, '1, '1, 128, 16'hFFFF)));
		pending_ops.push_back(with_answer(mk_op(ctpl_pkg::FN_UPDATE, 0, '1, '1, 1, 1, 5),
			hit(0, 64'h8000_0000_0000_0000, 0, 1, 1)));
		pending_ops.push_back(mk_op(ctpl_pkg::FN_UPDATE, 3, 64'h2001_0db8_0000_0001, '1,
			64, 100, 5));
		pending_ops.push_back(mk_op(ctpl_pkg::FN_UPDATE, 4, 64'h2001_0db8_0000_0001, '1,
			65, 50, 5));
		pending_ops.push_back(mk_op(ctpl_pkg::FN_LOOKUP, 0, 64'h2001_0db8_0000_0001, '1,
			0, 0, 5));
		pending_ops.push_back(mk_op(ctpl_pkg::FN_LOOKUP, 0, 64'h2001_0db8_0000_0001, 0,
			0, 0, 5));
		pending_ops.push_back(mk_op(ctpl_pkg::FN_UPDATE, 7, '1, '1, 128, 20, 5));
		pending_ops.push_back(mk_op(ctpl_pkg::FN_LOOKUP, 0, '1, '1, 0, 0, 6));
		pending_ops.push_back(mk_op(ctpl_pkg::FN_COUNT, 0, 0, 0, 0, 0, 6));
		pending_ops.push_back(with_answer(mk_op(ctpl_pkg::FN_BY_ID, 0, 0, 0, 0, 0, 6), none));
		pending_ops.push_back(with_answer(mk_op(ctpl_pkg::FN_REMOVE, 7, 0, 0, 0, 0, 6), none));
		pending_ops.push_back(with_answer(mk_op(ctpl_pkg::FN_RSVD6, 3, '1, '1, 8'hFF, '1, 7),
			none));
		pending_ops.push_back(with_answer(mk_op(ctpl_pkg::FN_RSVD7, 15, rnd64(), rnd64(),
			9, 9, 7), none));
		pending_ops.push_back(with_answer(mk_op(ctpl_pkg::FN_PURGE, 0, 0, 0, 0, 0, 60), none));
		pending_ops.push_back(mk_op(ctpl_pkg::FN_COUNT, 0, 0, 0, 0, 0, 60));
		pending_ops.push_back(mk_op(ctpl_pkg::FN_UPDATE, 1, 64'hFE80_0000_0000_0000, 0, 16,
			'1, 1000));
		// time running backwards saturates the remaining lifetime
		pending_ops.push_back(with_answer(mk_op(ctpl_pkg::FN_BY_ID, 1, 0, 0, 0, 0, 0),
			hit(1, 64'hFE80_0000_0000_0000, 0, 16, 16'hFFFF)));
		pending_ops.push_back(mk_op(ctpl_pkg::FN_UPDATE, 2, rnd64(), rnd64(), 128, '1, '1));
		pending_ops.push_back(mk_op(ctpl_pkg::FN_COUNT, 0, 0, 0, 0, 0, '1));
		pending_ops.push_back(mk_op(ctpl_pkg::FN_PURGE, 0, 0, 0, 0, 0, 0));

		for (int i = 0; i < 4; i++) begin
			bh[i] = rnd64();
			bl[i] = rnd64();
		end
		now = 0;
		for (int n = 0; n < N_RANDOM; n++) begin
			k = $urandom_range(3);
			// share a prefix of random length with one of the bases
			tail = {rnd64(), rnd64()} >> $urandom_range(128);
			r = $urandom_range(99);
			if (r < 3) now = now > 10 ? now - $urandom_range(10) : 0;
			else now = now + $urandom_range(3);
			q = mk_op(ctpl_pkg::FN_UPDATE, 4'($urandom_range(15)), bh[k] ^ tail[127:64],
				bl[k] ^ tail[63:0], 0, 0, now);
			if (n % 200 == 150) q.now = $urandom;
			r = $urandom_range(99);
			if (r < 35) begin
				q.fn = ctpl_pkg::FN_UPDATE;
				r = $urandom_range(99);
				q.len = r < 5 ? 8'd0 : r < 10 ? 8'($urandom_range(129, 255))
					: 8'($urandom_range(1, 128));
				r = $urandom_range(99);
				q.life = r < 10 ? 16'd0 : r < 25 ? 16'($urandom)
					: 16'($urandom_range(1, 30));
			end else if (r < 65) q.fn = ctpl_pkg::FN_LOOKUP;
			else if (r < 77) q.fn = ctpl_pkg::FN_BY_ID;
			else if (r < 85) q.fn = ctpl_pkg::FN_COUNT;
			else if (r < 92) q.fn = ctpl_pkg::FN_REMOVE;
			else if (r < 97) q.fn = ctpl_pkg::FN_PURGE;
			else q.fn = $urandom_range(1) ? ctpl_pkg::FN_RSVD6 : ctpl_pkg::FN_RSVD7;
			if (q.fn != ctpl_pkg::FN_UPDATE) begin
				q.len = 8'($urandom);
				q.life = 16'($urandom);
			end
			pending_ops.push_back(q);
		end
		total_ops = pending_ops.size();
		stim_done = 1'b1;
	end

	initial begin
		for (int unsigned i = 0; i < NENT; i++) ctx_clear(i);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// sender: hold the item until its transfer, then advance or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (cur.typed) begin
					void'(table_apply(cur));
					awaited.push_back(cur.want);
				end else
					awaited.push_back(table_apply(cur));
				accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (stim_done && pending_ops.size() != 0 &&
						$urandom_range(99) >= send_idle_pct()) begin
					cur = pending_ops.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= cur.fn;
					s_axis_tdata <= {4'b0, cur.now, cur.life, cur.len, cur.al, cur.ah, cur.id};
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall at random, compare each transfer with the oldest result
	always @(posedge clk or negedge arst_n) begin
		answer_t got;
		answer_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.found = m_axis_tdata[0];
				got.id    = m_axis_tdata[4:1];
				got.ph    = m_axis_tdata[68:5];
				got.pl    = m_axis_tdata[132:69];
				got.len   = m_axis_tdata[140:133];
				got.rem   = m_axis_tdata[156:141];
				got.cnt   = m_axis_tdata[161:157];
				if (awaited.size() == 0) begin
					$error("unexpected result transfer %h", m_axis_tdata);
					errors++;
				end else begin
					want = awaited.pop_front();
					if (got.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, got.found);
						errors++;
					end
					if (got.id !== want.id) begin
						$error("result_id: expected %0d, got %0d", want.id, got.id);
						errors++;
					end
					if (got.ph !== want.ph) begin
						$error("prefix_high: expected %h, got %h", want.ph, got.ph);
						errors++;
					end
					if (got.pl !== want.pl) begin
						$error("prefix_low: expected %h, got %h", want.pl, got.pl);
						errors++;
					end
					if (got.len !== want.len) begin
						$error("prefix_length_out: expected %0d, got %0d", want.len, got.len);
						errors++;
					end
					if (got.rem !== want.rem) begin
						$error("remaining_minutes: expected %0d, got %0d", want.rem, got.rem);
						errors++;
					end
					if (got.cnt !== want.cnt) begin
						$error("live_count: expected %0d, got %0d", want.cnt, got.cnt);
						errors++;
					end
				end
			end
			m_axis_tready <= $urandom_range(99) >= recv_idle_pct();
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		wait (accepted == total_ops && awaited.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0 && awaited.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
